[design/aqp_pkg.sv]
`timescale 1ns / 1ps
// Types and constants for the TPM2 quote report parser.
// No dependencies; imported by every module of the block.
package aqp_pkg;

	typedef struct packed {
		logic [7:0] report_byte;
		logic       is_last;
	} aqp_in_t;

	typedef struct packed {
		logic [7:0]  echo_byte;
		logic [1:0]  region;
		logic [4:0]  region_index;
		logic        done_res;
		logic        valid_report;
		logic [3:0]  error_code;
		logic [63:0] clock_millis;
		logic [31:0] reset_count;
		logic [31:0] restart_count;
		logic        clock_safe;
		logic [63:0] fw_version;
	} aqp_out_t;

	// error codes, first failure wins
	localparam logic [3:0] ERR_NONE      = 4'd0;
	localparam logic [3:0] ERR_MAGIC     = 4'd1;
	localparam logic [3:0] ERR_TYPE      = 4'd2;
	localparam logic [3:0] ERR_KEY_HDR   = 4'd3;
	localparam logic [3:0] ERR_NONCE_SZ  = 4'd4;
	localparam logic [3:0] ERR_SEL_CNT   = 4'd5;
	localparam logic [3:0] ERR_PCR_ALG   = 4'd6;
	localparam logic [3:0] ERR_PCR_MASK  = 4'd7;
	localparam logic [3:0] ERR_DIGEST_SZ = 4'd8;
	localparam logic [3:0] ERR_TRUNC     = 4'd9;
	localparam logic [3:0] ERR_TRAILING  = 4'd10;

	// region tags
	localparam logic [1:0] REG_OTHER  = 2'd0;
	localparam logic [1:0] REG_KEY    = 2'd1;
	localparam logic [1:0] REG_NONCE  = 2'd2;
	localparam logic [1:0] REG_DIGEST = 2'd3;

	// expected field values
	localparam logic [31:0] MAGIC_WORD   = 32'hff544347;
	localparam logic [15:0] QUOTE_TYPE   = 16'h8018;
	localparam logic [15:0] ALG_SHA256   = 16'h000b;
	localparam logic [31:0] PCR_MASK_ALL = 32'h03ffffff;
	localparam logic [7:0]  SAFE_BYTE    = 8'h01;
	localparam logic [15:0] HASH_LEN     = 16'd32;
	localparam logic [15:0] KEY_SIZE     = 16'd34;
	localparam logic [31:0] SEL_COUNT    = 32'd1;

	// byte offsets in the report
	localparam logic [7:0] POS_MAGIC_END   = 8'd3;
	localparam logic [7:0] POS_TYPE_END    = 8'd5;
	localparam logic [7:0] POS_KSIZE_END   = 8'd7;
	localparam logic [7:0] POS_KALG_END    = 8'd9;
	localparam logic [7:0] POS_KEY_HASH    = 8'd10;
	localparam logic [7:0] POS_NSIZE_END   = 8'd43;
	localparam logic [7:0] POS_NONCE       = 8'd44;
	localparam logic [7:0] POS_MILLIS      = 8'd76;
	localparam logic [7:0] POS_RESETS      = 8'd84;
	localparam logic [7:0] POS_RESTARTS    = 8'd88;
	localparam logic [7:0] POS_SAFE        = 8'd92;
	localparam logic [7:0] POS_FW          = 8'd93;
	localparam logic [7:0] POS_FW_END      = 8'd100;
	localparam logic [7:0] POS_SEL_END     = 8'd104;
	localparam logic [7:0] POS_PALG_END    = 8'd106;
	localparam logic [7:0] POS_MASK_END    = 8'd110;
	localparam logic [7:0] POS_DSIZE_END   = 8'd112;
	localparam logic [7:0] POS_DIGEST      = 8'd113;
	localparam logic [7:0] POS_LAST        = 8'd144;
	localparam logic [7:0] REPORT_LEN      = 8'd145;
	localparam logic [7:0] HASH_BYTES      = 8'd32;
	localparam logic [7:0] POS_MAX         = 8'd255;

endpackage

[design/aqp_parse.sv]
`timescale 1ns / 1ps
// Per-byte layout checker and field extractor; holds the report state.
// Depends on aqp_pkg.
module aqp_parse import aqp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  aqp_in_t  item,
	output aqp_out_t result
);

	logic [7:0]  pos_q;
	logic [3:0]  err_q;
	logic [31:0] shift_q;
	logic [63:0] millis_q;
	logic [31:0] resets_q;
	logic [31:0] restarts_q;
	logic        safe_q;
	logic [63:0] fw_q;

	logic [7:0]  b;
	logic [7:0]  p;
	logic [31:0] shift_n;
	logic [63:0] millis_n;
	logic [31:0] resets_n;
	logic [31:0] restarts_n;
	logic        safe_n;
	logic [63:0] fw_n;
	logic [3:0]  chk_code;
	logic [3:0]  err_a;
	logic [3:0]  err_n;

	assign b = item.report_byte;
	assign p = pos_q;
	assign shift_n = {shift_q[23:0], b};

	always_comb begin
		chk_code = ERR_NONE;
		case (p)
			POS_MAGIC_END: if (shift_n != MAGIC_WORD) chk_code = ERR_MAGIC;
			POS_TYPE_END:  if (shift_n[15:0] != QUOTE_TYPE) chk_code = ERR_TYPE;
			POS_KSIZE_END: if (shift_n[15:0] != KEY_SIZE) chk_code = ERR_KEY_HDR;
			POS_KALG_END:  if (shift_n[15:0] != ALG_SHA256) chk_code = ERR_KEY_HDR;
			POS_NSIZE_END: if (shift_n[15:0] != HASH_LEN) chk_code = ERR_NONCE_SZ;
			POS_SEL_END:   if (shift_n != SEL_COUNT) chk_code = ERR_SEL_CNT;
			POS_PALG_END:  if (shift_n[15:0] != ALG_SHA256) chk_code = ERR_PCR_ALG;
			POS_MASK_END:  if (shift_n != PCR_MASK_ALL) chk_code = ERR_PCR_MASK;
			POS_DSIZE_END: if (shift_n[15:0] != HASH_LEN) chk_code = ERR_DIGEST_SZ;
			default: begin
				if (p >= REPORT_LEN) chk_code = ERR_TRAILING;
			end
		endcase
	end

	assign err_a = (err_q != ERR_NONE) ? err_q : chk_code;
	assign err_n = (err_a != ERR_NONE) ? err_a :
		((item.is_last && p < POS_LAST) ? ERR_TRUNC : ERR_NONE);

	always_comb begin
		millis_n   = millis_q;
		resets_n   = resets_q;
		restarts_n = restarts_q;
		safe_n     = safe_q;
		fw_n       = fw_q;
		if (p >= POS_MILLIS && p < POS_RESETS) begin
			millis_n = {millis_q[55:0], b};
		end else if (p >= POS_RESETS && p < POS_RESTARTS) begin
			resets_n = {resets_q[23:0], b};
		end else if (p >= POS_RESTARTS && p < POS_SAFE) begin
			restarts_n = {restarts_q[23:0], b};
		end else if (p == POS_SAFE) begin
			safe_n = (b == SAFE_BYTE);
		end else if (p >= POS_FW && p <= POS_FW_END) begin
			fw_n = {fw_q[55:0], b};
		end
	end

	always_comb begin
		logic [7:0] off;
		off = 8'd0;
		result = '0;
		result.echo_byte = b;
		result.region = REG_OTHER;
		if (p >= POS_KEY_HASH && p < POS_KEY_HASH + HASH_BYTES) begin
			result.region = REG_KEY;
			off = p - POS_KEY_HASH;
		end else if (p >= POS_NONCE && p < POS_NONCE + HASH_BYTES) begin
			result.region = REG_NONCE;
			off = p - POS_NONCE;
		end else if (p >= POS_DIGEST && p < POS_DIGEST + HASH_BYTES) begin
			result.region = REG_DIGEST;
			off = p - POS_DIGEST;
		end
		result.region_index = off[4:0];
		result.done_res = item.is_last;
		if (item.is_last) begin
			result.valid_report  = (err_n == ERR_NONE);
			result.error_code    = err_n;
			result.clock_millis  = millis_n;
			result.reset_count   = resets_n;
			result.restart_count = restarts_n;
			result.clock_safe    = safe_n;
			result.fw_version    = fw_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			err_q      <= ERR_NONE;
			shift_q    <= '0;
			millis_q   <= '0;
			resets_q   <= '0;
			restarts_q <= '0;
			safe_q     <= 1'b0;
			fw_q       <= '0;
		end else if (step) begin
			if (item.is_last) begin
				// report closed: start fresh
				pos_q      <= '0;
				err_q      <= ERR_NONE;
				shift_q    <= '0;
				millis_q   <= '0;
				resets_q   <= '0;
				restarts_q <= '0;
				safe_q     <= 1'b0;
				fw_q       <= '0;
			end else begin
				if (pos_q != POS_MAX) pos_q <= pos_q + 8'd1;
				err_q      <= err_n;
				shift_q    <= shift_n;
				millis_q   <= millis_n;
				resets_q   <= resets_n;
				restarts_q <= restarts_n;
				safe_q     <= safe_n;
				fw_q       <= fw_n;
			end
		end
	end

endmodule

[design/attestation_quote_parser_core.sv]
`timescale 1ns / 1ps
// Top level of the TPM2 quote report parser: input register, checker, result register.
// Depends on aqp_pkg and aqp_parse.
//
//   channel | valid     | stall     | payload
//   request | req_valid | req_stall | req (aqp_in_t: one report byte + last flag)
//   result  | res_valid | res_stall | res (aqp_out_t: echo, tag, verdict, fields)
//
// One byte per cycle while the result does not stall; a byte taken into the input
// register is checked and lands in the result register once that register is free.
// Reset clears the report state and both valid flags; the next byte is offset 0.
// A stalled result holds; the input register keeps taking bytes until it is
// full behind a stalled result, then req_stall rises.
module attestation_quote_parser_core import aqp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  aqp_in_t  req,
	output logic     res_valid,
	input  logic     res_stall,
	output aqp_out_t res
);

	logic     valid_s1;
	aqp_in_t  req_s1;
	logic     res_valid_q;
	aqp_out_t res_q;
	logic     out_free;
	logic     advance;
	aqp_out_t parse_res;

	assign out_free  = !res_valid_q || !res_stall;
	assign advance   = valid_s1 && out_free;
	assign req_stall = valid_s1 && !out_free;

	aqp_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (req_s1),
		.result (parse_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) req_s1 <= req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) res_q <= parse_res;
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
